### rtl/delta_frame_run_decoder_core_defines.svh
// Assertion macros shared by the delta-frame run decoder RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef DELTA_FRAME_RUN_DECODER_CORE_DEFINES_SVH
`define DELTA_FRAME_RUN_DECODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Checked at every edge outside reset.
`define DFRD_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Checked at every edge, during reset too.
`define DFRD_ASSERT_ANY(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define DFRD_ASSERT_CLK(lbl, clk, rst_n, prop)
`define DFRD_ASSERT_ANY(lbl, clk, prop)
`endif

`endif

### rtl/dfrd_pkg.sv
// Opcode constants and the result type of the delta-frame run decoder.
// No dependencies; used by dfrd_parser and delta_frame_run_decoder_core.
package dfrd_pkg;

  localparam logic [7:0] OP_END0       = 8'h00;
  localparam logic [7:0] OP_END1       = 8'h13;
  localparam logic [7:0] OP_SKIP1      = 8'h02;
  localparam logic [7:0] OP_SKIP_B     = 8'h03;
  localparam logic [7:0] OP_SKIP_W     = 8'h04;
  localparam logic [7:0] OP_LIT_FIRST  = 8'h06;
  localparam logic [7:0] OP_LIT_LAST   = 8'h0a;
  localparam logic [7:0] OP_LIT_B      = 8'h0b;
  localparam logic [7:0] OP_LIT_W      = 8'h0c;
  localparam logic [7:0] OP_FILL_FIRST = 8'h0d;
  localparam logic [7:0] OP_FILL_LAST  = 8'h10;
  localparam logic [7:0] OP_FILL_B     = 8'h11;
  localparam logic [7:0] OP_FILL_W     = 8'h12;

  // Pair count of a short literal group is opcode minus LIT_BIAS, of a fill
  // code opcode minus FILL_BIAS.
  localparam logic [7:0] LIT_BIAS      = 8'h05;
  localparam logic [7:0] FILL_BIAS     = 8'h0d - 8'h02;

  localparam int TDATA_W = 48;

  typedef struct packed {
    logic        kind;
    logic [15:0] pixel_index;
    logic [14:0] pair_count;
    logic [7:0]  first_pixel;
    logic [7:0]  second_pixel;
    logic        clipped;
  } result_t;

endpackage

### rtl/dfrd_parser.sv
// Byte parser and position tracker of the delta-frame run decoder.
// Depends on dfrd_pkg and delta_frame_run_decoder_core_defines.svh.
`include "delta_frame_run_decoder_core_defines.svh"

module dfrd_parser #(
  parameter int FRAME_WIDTH  = 320,
  parameter int FRAME_HEIGHT = 200
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [7:0]        stream_byte,
  input  logic              frame_start,
  output logic              res_valid,
  output dfrd_pkg::result_t res
);

  localparam int FrameSize = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int PW = $clog2(FrameSize + 1);
  localparam int CW = (PW > 18) ? PW : 18;
  localparam logic [CW-1:0] SizeC = CW'(FrameSize);

  typedef enum logic [2:0] {
    PH_OPCODE,
    PH_COUNT_LO,
    PH_COUNT_HI,
    PH_PIX_A,
    PH_PIX_B
  } phase_t;

  phase_t        phase_r, phase_nxt, cur_phase;
  logic [4:0]    opcode_r, opcode_nxt, cur_opcode;
  logic [7:0]    cnt_lo_r, cnt_lo_nxt, cur_cnt_lo;
  logic [16:0]   run_r, run_nxt, cur_run;
  logic [7:0]    held_r, held_nxt, cur_held;
  logic [PW-1:0] pos_r, pos_nxt, cur_pos;
  // Room left to the frame end, kept beside the position so that the
  // saturation test is a single compare.
  logic [PW-1:0] room_r, room_nxt, cur_room;
  logic          ended_r, ended_nxt, cur_ended;

  logic [7:0]    op8;
  logic          is_literal;
  logic [16:0]   byte_plus1;
  logic [16:0]   word_plus1;
  logic [16:0]   run_dec;

  logic          adv_en;
  logic [16:0]   adv_pairs;
  logic [CW-1:0] two_p;
  logic [CW-1:0] pos_c;
  logic [CW-1:0] room_c;
  logic          sat;
  logic [PW-1:0] pos_adv;
  logic [PW-1:0] room_adv;

  logic [16:0]   wr_pairs;
  logic [CW-1:0] avail;
  logic [CW-1:0] wp;
  logic          short_run;
  logic [CW-1:0] take;
  logic          end_hit;

  // A frame start clears the parser before its byte is parsed.
  always_comb begin
    if (frame_start) begin
      cur_phase  = PH_OPCODE;
      cur_opcode = '0;
      cur_cnt_lo = '0;
      cur_run    = '0;
      cur_held   = '0;
      cur_pos    = '0;
      cur_room   = PW'(FrameSize);
      cur_ended  = 1'b0;
    end else begin
      cur_phase  = phase_r;
      cur_opcode = opcode_r;
      cur_cnt_lo = cnt_lo_r;
      cur_run    = run_r;
      cur_held   = held_r;
      cur_pos    = pos_r;
      cur_room   = room_r;
      cur_ended  = ended_r;
    end
  end

  assign op8        = {3'b000, cur_opcode};
  assign is_literal = op8 inside {[dfrd_pkg::OP_LIT_FIRST:dfrd_pkg::OP_LIT_W]};
  assign byte_plus1 = 17'(stream_byte) + 17'd1;
  assign word_plus1 = 17'({stream_byte, cur_cnt_lo}) + 17'd1;
  assign run_dec    = cur_run - 17'd1;

  always_comb begin
    phase_nxt  = cur_phase;
    opcode_nxt = cur_opcode;
    cnt_lo_nxt = cur_cnt_lo;
    run_nxt    = cur_run;
    held_nxt   = cur_held;
    ended_nxt  = cur_ended;
    adv_en     = 1'b0;
    adv_pairs  = '0;
    wr_pairs   = '0;
    res_valid  = 1'b0;
    end_hit    = 1'b0;
    if (!cur_ended) begin
      case (cur_phase)
        PH_COUNT_LO: begin
          cnt_lo_nxt = stream_byte;
          if (op8 == dfrd_pkg::OP_SKIP_B) begin
            adv_en    = 1'b1;
            adv_pairs = byte_plus1;
            phase_nxt = PH_OPCODE;
          end else if (op8 inside {dfrd_pkg::OP_LIT_B, dfrd_pkg::OP_FILL_B}) begin
            run_nxt   = byte_plus1;
            phase_nxt = PH_PIX_A;
          end else begin
            phase_nxt = PH_COUNT_HI;
          end
        end
        PH_COUNT_HI: begin
          if (op8 == dfrd_pkg::OP_SKIP_W) begin
            adv_en    = 1'b1;
            adv_pairs = word_plus1;
            phase_nxt = PH_OPCODE;
          end else begin
            run_nxt   = word_plus1;
            phase_nxt = PH_PIX_A;
          end
        end
        PH_PIX_A: begin
          held_nxt  = stream_byte;
          phase_nxt = PH_PIX_B;
        end
        PH_PIX_B: begin
          res_valid = 1'b1;
          adv_en    = 1'b1;
          if (is_literal) begin
            wr_pairs  = 17'd1;
            run_nxt   = run_dec;
            phase_nxt = (run_dec != '0) ? PH_PIX_A : PH_OPCODE;
          end else begin
            wr_pairs  = cur_run;
            run_nxt   = '0;
            phase_nxt = PH_OPCODE;
          end
          adv_pairs = wr_pairs;
        end
        default: begin
          phase_nxt = PH_OPCODE;
          if (stream_byte inside {dfrd_pkg::OP_END0, dfrd_pkg::OP_END1}) begin
            opcode_nxt = stream_byte[4:0];
            ended_nxt  = 1'b1;
            res_valid  = 1'b1;
            end_hit    = 1'b1;
          end else if (stream_byte == dfrd_pkg::OP_SKIP1) begin
            opcode_nxt = stream_byte[4:0];
            adv_en     = 1'b1;
            adv_pairs  = 17'd1;
          end else if (stream_byte inside {dfrd_pkg::OP_SKIP_B, dfrd_pkg::OP_SKIP_W,
                                           dfrd_pkg::OP_LIT_B, dfrd_pkg::OP_LIT_W,
                                           dfrd_pkg::OP_FILL_B, dfrd_pkg::OP_FILL_W}) begin
            opcode_nxt = stream_byte[4:0];
            phase_nxt  = PH_COUNT_LO;
          end else if (stream_byte inside
                       {[dfrd_pkg::OP_LIT_FIRST:dfrd_pkg::OP_LIT_LAST]}) begin
            opcode_nxt = stream_byte[4:0];
            run_nxt    = 17'(stream_byte - dfrd_pkg::LIT_BIAS);
            phase_nxt  = PH_PIX_A;
          end else if (stream_byte inside
                       {[dfrd_pkg::OP_FILL_FIRST:dfrd_pkg::OP_FILL_LAST]}) begin
            opcode_nxt = stream_byte[4:0];
            run_nxt    = 17'(stream_byte - dfrd_pkg::FILL_BIAS);
            phase_nxt  = PH_PIX_A;
          end
        end
      endcase
    end
  end

  // Position advance, saturating at the frame end.
  assign pos_c    = CW'(cur_pos);
  assign room_c   = CW'(cur_room);
  assign two_p    = CW'({adv_pairs, 1'b0});
  assign sat      = (two_p >= room_c);
  assign pos_adv  = sat ? SizeC[PW-1:0] : PW'(pos_c + two_p);
  assign room_adv = sat ? '0 : PW'(room_c - two_p);
  assign pos_nxt  = adv_en ? pos_adv : cur_pos;
  assign room_nxt = adv_en ? room_adv : cur_room;

  // Only pairs with both pixels inside the frame are written.
  assign avail     = room_c >> 1;
  assign wp        = CW'(wr_pairs);
  assign short_run = (avail < wp);
  assign take      = short_run ? avail : wp;

  always_comb begin
    res.kind         = end_hit;
    res.pixel_index  = pos_c[15:0];
    res.pair_count   = end_hit ? '0 : take[14:0];
    res.first_pixel  = end_hit ? '0 : cur_held;
    res.second_pixel = end_hit ? '0 : stream_byte;
    res.clipped      = end_hit ? 1'b0 : short_run;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_OPCODE;
      opcode_r <= '0;
      cnt_lo_r <= '0;
      run_r    <= '0;
      held_r   <= '0;
      pos_r    <= '0;
      room_r   <= PW'(FrameSize);
      ended_r  <= 1'b0;
    end else if (en) begin
      phase_r  <= phase_nxt;
      opcode_r <= opcode_nxt;
      cnt_lo_r <= cnt_lo_nxt;
      run_r    <= run_nxt;
      held_r   <= held_nxt;
      pos_r    <= pos_nxt;
      room_r   <= room_nxt;
      ended_r  <= ended_nxt;
    end
  end

  `DFRD_ASSERT_CLK(a_pos_room_sum, clk, rst_n, (CW'(pos_r) + CW'(room_r)) == SizeC)
  `DFRD_ASSERT_CLK(a_pos_bound, clk, rst_n, CW'(pos_r) <= SizeC)
  `DFRD_ASSERT_CLK(a_ended_idle, clk, rst_n, ended_r |-> (phase_r == PH_OPCODE))

endmodule

### rtl/delta_frame_run_decoder_core.sv
// Delta-frame run decoder: turns an encoded byte stream into framebuffer
// write commands (literal pairs and filled runs) and an end-of-frame mark.
// Usage: bytes enter on the in_ channel, one transaction per byte; set
// in_tuser on the first byte of a frame to restart position and parser.
// Each byte yields zero or one transaction on the out_ channel: a write
// command (out_tuser 0) or the end of the frame (out_tuser 1); after the
// end mark, bytes are swallowed until the next frame start.
// Throughput: one byte per cycle while out_tready is high. A byte is held in
// the input register until processed, and its result then goes into the
// output register; the parse, the position advance and the run clip are
// one compare-and-add pass between those two registers.
// Receiver stall: while a result waits in the output register, the byte in
// the input register is held and in_tready drops once that register is full.
// Reset (rst_n low, synchronous): both registers empty, position zero,
// parser waiting for an opcode.
// Depends on dfrd_pkg, dfrd_parser and delta_frame_run_decoder_core_defines.svh.
`include "delta_frame_run_decoder_core_defines.svh"

module delta_frame_run_decoder_core #(
  parameter int FRAME_WIDTH  = 320,
  parameter int FRAME_HEIGHT = 200
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [7:0] stream_byte
  input  logic [0:0]                   in_tuser,   // [0] frame_start
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [15:0] pixel_index, [30:16] pair_count, [38:31] first_pixel,
  // [46:39] second_pixel, [47] clipped
  output logic [dfrd_pkg::TDATA_W-1:0] out_tdata,
  output logic [0:0]                   out_tuser   // [0] kind
);

  logic              in_v_r;
  logic [7:0]        in_byte_r;
  logic              in_start_r;
  logic              out_v_r;
  logic [dfrd_pkg::TDATA_W-1:0] out_data_r, out_data_nxt;
  logic              out_kind_r;
  logic              proc_en;
  logic              res_valid;
  dfrd_pkg::result_t res;

  assign proc_en   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || proc_en;

  dfrd_parser #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (proc_en),
    .stream_byte(in_byte_r),
    .frame_start(in_start_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  assign out_data_nxt = {res.clipped, res.second_pixel, res.first_pixel,
                         res.pair_count, res.pixel_index};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (proc_en && res_valid) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r  <= in_tdata;
      in_start_r <= in_tuser[0];
    end
    if (proc_en && res_valid) begin
      out_data_r <= out_data_nxt;
      out_kind_r <= res.kind;
    end
  end

  assign out_tvalid   = out_v_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_kind_r;

  `DFRD_ASSERT_ANY(a_stall_has_item, clk, !in_tready |-> in_v_r)
  `DFRD_ASSERT_CLK(a_accept_fills, clk, rst_n, (in_tvalid && in_tready) |=> in_v_r)
  `DFRD_ASSERT_CLK(a_end_mark_empty, clk, rst_n,
    (out_tvalid && out_tuser[0]) |-> ((out_tdata[30:16] == 15'd0) && !out_tdata[47]))

endmodule
